FILE: sv/ufsi_pkg.sv
// shared widths, sizes, queue command and back-end state type for the
// first-seen indexer; no dependencies
package ufsi_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = $clog2(Q_DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_INDEX = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              inc;
    logic              ovf;
    logic              last;
    logic [FILL_W-1:0] fill;
  } ufsi_cmd_t;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } ufsi_state_e;

endpackage

FILE: sv/ufsi_in_if.sv
// input channel: one data element per request
// depends on ufsi_pkg
interface ufsi_in_if;
  logic                        valid;
  logic                        ready;
  logic [ufsi_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

FILE: sv/ufsi_out_if.sv
// output channel: index results and drain entries
// depends on ufsi_pkg
interface ufsi_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ufsi_pkg::SLOT_W-1:0]  slot;
  logic [ufsi_pkg::VALUE_W-1:0] unique_value;
  logic [ufsi_pkg::COUNT_W-1:0] entry_count;
  logic                         overflow;
  logic                         run_end;

  modport source (output valid, output kind, output slot, output unique_value,
                  output entry_count, output overflow, output run_end, input ready);
  modport sink (input valid, input kind, input slot, input unique_value,
                input entry_count, input overflow, input run_end, output ready);
endinterface

FILE: sv/ufsi_front.sv
// front end: parallel lookup in the value table, insert of new values,
// command push to the queue; depends on ufsi_pkg and ufsi_in_if
module ufsi_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ufsi_in_if.sink                       in_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output ufsi_pkg::ufsi_cmd_t           q_cmd_o,
  input  logic                          drain_done_i,
  input  logic [ufsi_pkg::SLOT_W-1:0]   rd_idx_i,
  output logic [ufsi_pkg::VALUE_W-1:0]  rd_value_o
);

  logic [ufsi_pkg::VALUE_W-1:0]     table_q [ufsi_pkg::TABLE_DEPTH];
  logic [ufsi_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic                             hold_q, hold_d;
  logic [ufsi_pkg::TABLE_DEPTH-1:0] hit;
  logic [ufsi_pkg::SLOT_W-1:0]      hit_slot;
  logic                             found, full, insert, accept;

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < ufsi_pkg::TABLE_DEPTH; i++) begin
      hit[i] = (ufsi_pkg::FILL_W'(i) < fill_q) && (table_q[i] == in_i.value);
      hit_slot = hit_slot | (hit[i] ? ufsi_pkg::SLOT_W'(i) : '0);
    end
  end

  assign found      = |hit;
  assign full       = (fill_q == ufsi_pkg::FILL_W'(ufsi_pkg::TABLE_DEPTH));
  assign in_i.ready = !q_full_i && !hold_q;
  assign accept     = in_i.valid && in_i.ready;
  assign insert     = accept && !found && !full;
  assign q_push_o   = accept;
  assign rd_value_o = table_q[rd_idx_i];

  always_comb begin
    q_cmd_o.ovf  = !found && full;
    q_cmd_o.inc  = !q_cmd_o.ovf;
    q_cmd_o.last = in_i.last;
    q_cmd_o.slot = found ? hit_slot : (full ? '0 : fill_q[ufsi_pkg::SLOT_W-1:0]);
    q_cmd_o.fill = (!found && !full) ? fill_q + 1'b1 : fill_q;
    fill_d = fill_q;
    hold_d = hold_q;
    if (drain_done_i) begin
      hold_d = 1'b0;
    end
    if (accept) begin
      fill_d = in_i.last ? '0 : q_cmd_o.fill;
      hold_d = in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hold_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ufsi_pkg::TABLE_DEPTH; i++) begin
      if (insert && (fill_q == ufsi_pkg::FILL_W'(i))) begin
        table_q[i] <= in_i.value;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ufsi_pkg::FILL_W'(ufsi_pkg::TABLE_DEPTH))
    else $error("fill level beyond table depth");

  a_hold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.last) |=> !in_i.ready)
    else $error("request taken while drain pending");

endmodule

FILE: sv/ufsi_cmd_fifo.sv
// short command queue between front and back ends
// depends on ufsi_pkg
module ufsi_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ufsi_pkg::ufsi_cmd_t cmd_i,
  input  logic                pop_i,
  output ufsi_pkg::ufsi_cmd_t cmd_o,
  output logic                full_o,
  output logic                empty_o
);

  ufsi_pkg::ufsi_cmd_t          mem_q [ufsi_pkg::Q_DEPTH];
  logic [ufsi_pkg::Q_PTR_W-1:0] wr_q, rd_q;
  logic [ufsi_pkg::Q_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (ufsi_pkg::Q_PTR_W + 1)'(ufsi_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("command queue overrun");

endmodule

FILE: sv/ufsi_back.sv
// back end: occurrence counters, result register and drain sequencer
// depends on ufsi_pkg and ufsi_out_if
module ufsi_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          q_empty_i,
  input  ufsi_pkg::ufsi_cmd_t           q_cmd_i,
  output logic                          q_pop_o,
  output logic                          drain_done_o,
  output logic [ufsi_pkg::SLOT_W-1:0]   rd_idx_o,
  input  logic [ufsi_pkg::VALUE_W-1:0]  rd_value_i,
  ufsi_out_if.source                    out_o
);

  ufsi_pkg::ufsi_state_e        state_q, state_d;
  logic [ufsi_pkg::COUNT_W-1:0] cnt_q [ufsi_pkg::TABLE_DEPTH];
  logic [ufsi_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic [ufsi_pkg::FILL_W-1:0]  dfill_q, dfill_d;
  logic                         cen_q;
  logic                         vld_q, vld_d;
  logic                         kind_q, kind_d;
  logic [ufsi_pkg::SLOT_W-1:0]  slot_q, slot_d;
  logic [ufsi_pkg::VALUE_W-1:0] uval_q, uval_d;
  logic [ufsi_pkg::COUNT_W-1:0] ecnt_q, ecnt_d;
  logic                         ovf_q, ovf_d;
  logic                         end_q, end_d;
  logic                         load_ok, inc, clr, drain_last;

  assign load_ok    = !vld_q || out_o.ready;
  assign rd_idx_o   = idx_q;
  assign drain_last = ({1'b0, idx_q} + 1'b1) == dfill_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    dfill_d      = dfill_q;
    q_pop_o      = 1'b0;
    inc          = 1'b0;
    clr          = 1'b0;
    drain_done_o = 1'b0;
    kind_d       = kind_q;
    slot_d       = slot_q;
    uval_d       = uval_q;
    ecnt_d       = ecnt_q;
    ovf_d        = ovf_q;
    end_d        = end_q;
    vld_d        = out_o.ready ? 1'b0 : vld_q;
    unique case (state_q)
      ufsi_pkg::ST_RUN: begin
        if (!q_empty_i && load_ok) begin
          q_pop_o = 1'b1;
          inc     = q_cmd_i.inc;
          vld_d   = 1'b1;
          kind_d  = ufsi_pkg::KIND_INDEX;
          slot_d  = q_cmd_i.slot;
          uval_d  = '0;
          ecnt_d  = '0;
          ovf_d   = q_cmd_i.ovf;
          end_d   = !q_cmd_i.last;
          if (q_cmd_i.last) begin
            state_d = ufsi_pkg::ST_DRAIN;
            idx_d   = '0;
            dfill_d = q_cmd_i.fill;
          end
        end
      end
      ufsi_pkg::ST_DRAIN: begin
        if (load_ok) begin
          vld_d  = 1'b1;
          kind_d = ufsi_pkg::KIND_ENTRY;
          slot_d = idx_q;
          uval_d = rd_value_i;
          ecnt_d = cen_q ? cnt_q[idx_q] : '0;
          ovf_d  = 1'b0;
          end_d  = drain_last;
          if (drain_last) begin
            clr          = 1'b1;
            drain_done_o = 1'b1;
            state_d      = ufsi_pkg::ST_RUN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ufsi_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ufsi_pkg::ST_RUN;
      idx_q   <= '0;
      dfill_q <= '0;
      vld_q   <= 1'b0;
      cen_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dfill_q <= dfill_d;
      vld_q   <= vld_d;
      if (cfg_we_i) begin
        cen_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ufsi_pkg::TABLE_DEPTH; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ufsi_pkg::TABLE_DEPTH; i++) begin
        if (clr) begin
          cnt_q[i] <= '0;
        end else if (inc && (q_cmd_i.slot == ufsi_pkg::SLOT_W'(i)) &&
                     (cnt_q[i] != ufsi_pkg::COUNT_MAX)) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    slot_q <= slot_d;
    uval_q <= uval_d;
    ecnt_q <= ecnt_d;
    ovf_q  <= ovf_d;
    end_q  <= end_d;
  end

  assign out_o.valid        = vld_q;
  assign out_o.kind         = kind_q;
  assign out_o.slot         = slot_q;
  assign out_o.unique_value = uval_q;
  assign out_o.entry_count  = ecnt_q;
  assign out_o.overflow     = ovf_q;
  assign out_o.run_end      = end_q;

  a_drain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ufsi_pkg::ST_DRAIN) |-> ({1'b0, idx_q} < dfill_q))
    else $error("drain index past fill level");

  a_counts_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_done_o |=> (cnt_q[0] == '0) && (state_q == ufsi_pkg::ST_RUN))
    else $error("counts not cleared after drain");

endmodule

FILE: sv/unique_first_seen_indexer.sv
// an accepted element's result passes the command queue and then the result register
// throughput: 1 element per cycle (combinational parallel lookup) unless the queue is
// full or a drain is pending; a last element adds one drain result per stored value
// (1 to 32); the front end takes no new element until the last drain result is loaded
// reset: table empty, all counts zero, queue empty, counts_enable = 1; no clearing pass
module unique_first_seen_indexer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  ufsi_in_if.sink    in_i,
  ufsi_out_if.source out_o
);

  ufsi_pkg::ufsi_cmd_t          push_cmd, pop_cmd;
  logic                         push, pop, q_full, q_empty, drain_done;
  logic [ufsi_pkg::SLOT_W-1:0]  rd_idx;
  logic [ufsi_pkg::VALUE_W-1:0] rd_value;

  ufsi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .q_full_i     (q_full),
    .q_push_o     (push),
    .q_cmd_o      (push_cmd),
    .drain_done_i (drain_done),
    .rd_idx_i     (rd_idx),
    .rd_value_o   (rd_value)
  );

  ufsi_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ufsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_empty_i    (q_empty),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (pop),
    .drain_done_o (drain_done),
    .rd_idx_o     (rd_idx),
    .rd_value_i   (rd_value),
    .out_o        (out_o)
  );

endmodule
